FILE: hdl/snpd_pkg.sv
// Shared types and constants of the Snappy block decompressor.
// It depends on nothing. The top level uses it.
`timescale 1ns / 1ps

package snpd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TAG,
    PH_LIT_EXTRA,
    PH_LITERAL,
    PH_COPY_EXTRA,
    PH_IDLE
  } phase_e;

  typedef enum logic [1:0] {
    ST_IN,
    ST_SETUP,
    ST_RD,
    ST_WR
  } seq_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_OFF   = 2'd1,
    STAT_TRUNC     = 2'd2,
    STAT_TOO_LARGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TAG_LITERAL = 2'd0,
    TAG_COPY1   = 2'd1,
    TAG_COPY2   = 2'd2,
    TAG_COPY4   = 2'd3
  } tag_kind_e;

  localparam logic [31:0] MAX_LENGTH_RESET = 32'd67108864;
  localparam logic [6:0]  VARINT_MASK      = 7'h7f;
  localparam logic [5:0]  VARINT_LAST_SH   = 6'd28;
  localparam logic [6:0]  VARINT_TOP_MAX   = 7'h0f;
  localparam logic [5:0]  LIT_SHORT_MAX    = 6'd59;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       out_last;
    status_e    status;
  } out_item_t;

endpackage

FILE: hdl/snpd_if.sv
// Handshake channels of the Snappy block decompressor: input, result and configuration.
// They depend on no other file.
`timescale 1ns / 1ps

interface snpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface snpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_data;
  logic       out_last;
  logic [1:0] status;
  modport source (output valid, output out_byte, output has_data, output out_last,
                  output status, input ready);
  modport sink (input valid, input out_byte, input has_data, input out_last,
                input status, output ready);
endinterface

interface snpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] max_length;
  modport source (output valid, output max_length, input ready);
  modport sink (input valid, input max_length, output ready);
endinterface

FILE: hdl/snappy_block_decompressor.sv
// Snappy raw block decompressor: one compressed byte in per item, decompressed bytes out.
// It depends on snpd_pkg and on the channel interfaces in snpd_if.
`timescale 1ns / 1ps

// The block accepts one compressed byte per cycle for headers, tags, extra bytes and
// literals while the result register is free and no copy runs, each literal byte leaving
// as one result item. A copy first checks its offset and then replays each byte by a
// registered read from the single port history memory, then the write and the result;
// input is held off until the copy ends. Errors latch and show on the results of
// the final byte; the byte marked last always gives at least one result with out_last set.
// The history memory needs no clearing after reset.
module snappy_block_decompressor #(
  parameter int HISTORY_DEPTH = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  snpd_in_if.sink    in_i,
  snpd_out_if.source out_o,
  snpd_cfg_if.sink   cfg_i
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0]  DEPTH_A = (AW+1)'(HISTORY_DEPTH);
  localparam logic [31:0]  DEPTH_W = 32'(HISTORY_DEPTH);

  logic [7:0] mem_q [HISTORY_DEPTH];
  logic [7:0] rd_q;

  snpd_pkg::seq_e      state_q, state_d;
  snpd_pkg::phase_e    phase_q, phase_d;
  snpd_pkg::status_e   err_q, err_d;
  logic [AW-1:0]       wp_q, wp_d;
  logic [31:0]         produced_q, produced_d;
  logic [31:0]         declared_q, declared_d;
  logic [31:0]         asm_q, asm_d;
  logic [32:0]         litrem_q, litrem_d;
  logic [5:0]          shift_q, shift_d;
  logic [7:0]          tag_q, tag_d;
  logic [2:0]          left_q, left_d;
  logic [31:0]         maxlen_q;
  logic [31:0]         offset_q, offset_d;
  logic [6:0]          len_q, len_d;
  logic                blast_q, blast_d;
  logic [AW-1:0]       src_q, src_d;
  logic [6:0]          cnt_q, cnt_d;
  snpd_pkg::status_e   cstat_q, cstat_d;
  logic                out_valid_q, out_valid_d;
  snpd_pkg::out_item_t out_q, out_d;

  logic          in_fire, out_free, copy_go, setup_bad;
  logic          mem_we;
  logic [7:0]    mem_wd;
  logic [6:0]    payload;
  logic [31:0]   asm_hdr, asm_ext, remaining;
  logic [2:0]    total, left_n;
  logic [1:0]    idx;
  logic [AW:0]   wp_ext, off_ext, src_calc;
  logic [AW-1:0] wp_inc, src_inc;

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == snpd_pkg::ST_IN) && out_free;
  assign in_fire   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_q.out_byte;
  assign out_o.has_data = out_q.has_data;
  assign out_o.out_last = out_q.out_last;
  assign out_o.status   = out_q.status;

  assign payload = in_i.in_byte[6:0] & snpd_pkg::VARINT_MASK;
  assign asm_hdr = asm_q | (32'(payload) << shift_q[4:0]);

  always_comb begin
    case (snpd_pkg::tag_kind_e'(tag_q[1:0]))
      snpd_pkg::TAG_LITERAL: total = 3'(tag_q[7:2] - snpd_pkg::LIT_SHORT_MAX);
      snpd_pkg::TAG_COPY1:   total = 3'd1;
      snpd_pkg::TAG_COPY2:   total = 3'd2;
      default:               total = 3'd4;
    endcase
  end
  assign idx     = 2'(total - left_q);
  assign asm_ext = asm_q | (32'(in_i.in_byte) << {idx, 3'b000});
  assign left_n  = (left_q != 3'd0) ? left_q - 3'd1 : 3'd0;

  assign wp_inc  = (AW+1)'({1'b0, wp_q} + 1'b1) == DEPTH_A ? '0 : wp_q + 1'b1;
  assign src_inc = (AW+1)'({1'b0, src_q} + 1'b1) == DEPTH_A ? '0 : src_q + 1'b1;
  assign wp_ext  = {1'b0, wp_q};
  assign off_ext = offset_q[AW:0];
  assign src_calc = (wp_ext >= off_ext) ? wp_ext - off_ext : wp_ext + DEPTH_A - off_ext;
  assign remaining = declared_q - produced_q;
  assign setup_bad = (offset_q == 32'd0) || (offset_q > produced_q) || (offset_q > DEPTH_W);

  always_comb begin
    phase_d    = phase_q;
    err_d      = err_q;
    wp_d       = wp_q;
    produced_d = produced_q;
    declared_d = declared_q;
    asm_d      = asm_q;
    litrem_d   = litrem_q;
    shift_d    = shift_q;
    tag_d      = tag_q;
    left_d     = left_q;
    offset_d   = offset_q;
    len_d      = len_q;
    blast_d    = blast_q;
    src_d      = src_q;
    cnt_d      = cnt_q;
    cstat_d    = cstat_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mem_we     = 1'b0;
    mem_wd     = in_i.in_byte;
    copy_go    = 1'b0;

    unique case (state_q)
      snpd_pkg::ST_IN: begin
        if (in_fire) begin
          out_d.out_byte = in_i.in_byte;
          out_d.has_data = 1'b0;
          unique case (phase_q) inside
            snpd_pkg::PH_HEADER: begin
              if (shift_q >= snpd_pkg::VARINT_LAST_SH &&
                  (in_i.in_byte[7] || payload > snpd_pkg::VARINT_TOP_MAX)) begin
                err_d   = snpd_pkg::STAT_TOO_LARGE;
                phase_d = snpd_pkg::PH_IDLE;
              end else if (in_i.in_byte[7]) begin
                asm_d   = asm_hdr;
                shift_d = shift_q + 6'd7;
              end else begin
                declared_d = asm_hdr;
                asm_d      = '0;
                shift_d    = '0;
                if (asm_hdr > maxlen_q) begin
                  err_d   = snpd_pkg::STAT_TOO_LARGE;
                  phase_d = snpd_pkg::PH_IDLE;
                end else if (asm_hdr == 32'd0) begin
                  phase_d = snpd_pkg::PH_IDLE;
                end else begin
                  phase_d = snpd_pkg::PH_TAG;
                end
              end
            end
            snpd_pkg::PH_TAG: begin
              tag_d = in_i.in_byte;
              asm_d = '0;
              if (in_i.in_byte[1:0] == snpd_pkg::TAG_LITERAL) begin
                if (in_i.in_byte[7:2] <= snpd_pkg::LIT_SHORT_MAX) begin
                  litrem_d = 33'(in_i.in_byte[7:2]) + 33'd1;
                  phase_d  = snpd_pkg::PH_LITERAL;
                end else begin
                  left_d  = 3'(in_i.in_byte[7:2] - snpd_pkg::LIT_SHORT_MAX);
                  phase_d = snpd_pkg::PH_LIT_EXTRA;
                end
              end else begin
                left_d  = (in_i.in_byte[1:0] == snpd_pkg::TAG_COPY1) ? 3'd1 :
                          (in_i.in_byte[1:0] == snpd_pkg::TAG_COPY2) ? 3'd2 : 3'd4;
                phase_d = snpd_pkg::PH_COPY_EXTRA;
              end
            end
            snpd_pkg::PH_LIT_EXTRA, snpd_pkg::PH_COPY_EXTRA: begin
              asm_d  = asm_ext;
              left_d = left_n;
              if (left_n == 3'd0) begin
                if (phase_q == snpd_pkg::PH_LIT_EXTRA) begin
                  litrem_d = 33'(asm_ext) + 33'd1;
                  asm_d    = '0;
                  phase_d  = snpd_pkg::PH_LITERAL;
                end else begin
                  copy_go = 1'b1;
                  asm_d   = '0;
                  blast_d = in_i.in_last;
                  if (tag_q[1:0] == snpd_pkg::TAG_COPY1) begin
                    len_d    = 7'(tag_q[4:2]) + 7'd4;
                    offset_d = {21'd0, tag_q[7:5], asm_ext[7:0]};
                  end else begin
                    len_d    = 7'(tag_q[7:2]) + 7'd1;
                    offset_d = asm_ext;
                  end
                end
              end
            end
            snpd_pkg::PH_LITERAL: begin
              mem_we         = 1'b1;
              wp_d           = wp_inc;
              produced_d     = produced_q + 32'd1;
              out_d.has_data = 1'b1;
              litrem_d       = (litrem_q != 33'd0) ? litrem_q - 33'd1 : 33'd0;
              if (produced_q + 32'd1 == declared_q) begin
                phase_d = snpd_pkg::PH_IDLE;
              end else if (litrem_d == 33'd0) begin
                phase_d = snpd_pkg::PH_TAG;
              end
            end
            default: begin
            end
          endcase

          if (!copy_go) begin
            out_d.out_last = in_i.in_last;
            out_d.status   = (in_i.in_last && phase_d != snpd_pkg::PH_IDLE &&
                              err_d == snpd_pkg::STAT_OK) ? snpd_pkg::STAT_TRUNC : err_d;
            if (out_d.has_data || in_i.in_last) begin
              out_valid_d = 1'b1;
            end
            if (!out_d.has_data) begin
              out_d.out_byte = '0;
            end
          end
        end
      end
      snpd_pkg::ST_SETUP: begin
        if (out_free) begin
          if (setup_bad) begin
            err_d   = snpd_pkg::STAT_BAD_OFF;
            phase_d = snpd_pkg::PH_IDLE;
            if (blast_q) begin
              out_d.out_byte = '0;
              out_d.has_data = 1'b0;
              out_d.out_last = 1'b1;
              out_d.status   = snpd_pkg::STAT_BAD_OFF;
              out_valid_d    = 1'b1;
            end
          end else begin
            src_d   = AW'(src_calc);
            cnt_d   = (32'(len_q) >= remaining) ? 7'(remaining) : len_q;
            cstat_d = (blast_q && !(32'(len_q) >= remaining)) ?
                      snpd_pkg::STAT_TRUNC : snpd_pkg::STAT_OK;
            phase_d = (32'(len_q) >= remaining) ? snpd_pkg::PH_IDLE : snpd_pkg::PH_TAG;
          end
        end
      end
      snpd_pkg::ST_RD: begin
      end
      snpd_pkg::ST_WR: begin
        if (out_free) begin
          mem_we         = 1'b1;
          mem_wd         = rd_q;
          wp_d           = wp_inc;
          src_d          = src_inc;
          produced_d     = produced_q + 32'd1;
          cnt_d          = cnt_q - 7'd1;
          out_d.out_byte = rd_q;
          out_d.has_data = 1'b1;
          out_d.out_last = blast_q && (cnt_q == 7'd1);
          out_d.status   = cstat_q;
          out_valid_d    = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if ((state_q == snpd_pkg::ST_IN && in_fire && !copy_go && in_i.in_last) ||
        (state_q == snpd_pkg::ST_SETUP && out_free && setup_bad && blast_q) ||
        (state_q == snpd_pkg::ST_WR && out_free && cnt_q == 7'd1 && blast_q)) begin
      wp_d       = '0;
      produced_d = '0;
      declared_d = '0;
      asm_d      = '0;
      litrem_d   = '0;
      phase_d    = snpd_pkg::PH_HEADER;
      shift_d    = '0;
      tag_d      = '0;
      left_d     = '0;
      err_d      = snpd_pkg::STAT_OK;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      snpd_pkg::ST_IN:    if (copy_go) state_d = snpd_pkg::ST_SETUP;
      snpd_pkg::ST_SETUP: begin
        if (out_free) begin
          state_d = setup_bad ? snpd_pkg::ST_IN : snpd_pkg::ST_RD;
        end
      end
      snpd_pkg::ST_RD:    state_d = snpd_pkg::ST_WR;
      snpd_pkg::ST_WR: begin
        if (out_free) begin
          state_d = (cnt_q == 7'd1) ? snpd_pkg::ST_IN : snpd_pkg::ST_RD;
        end
      end
      default:            state_d = snpd_pkg::ST_IN;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= mem_wd;
    end
    if (state_q == snpd_pkg::ST_RD) begin
      rd_q <= mem_q[src_q];
    end
  end

  always_ff @(posedge clk_i) begin
    offset_q <= offset_d;
    len_q    <= len_d;
    src_q    <= src_d;
    cnt_q    <= cnt_d;
    cstat_q  <= cstat_d;
    out_q    <= out_d;
    tag_q    <= tag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= snpd_pkg::ST_IN;
      phase_q     <= snpd_pkg::PH_HEADER;
      err_q       <= snpd_pkg::STAT_OK;
      wp_q        <= '0;
      produced_q  <= '0;
      declared_q  <= '0;
      asm_q       <= '0;
      litrem_q    <= '0;
      shift_q     <= '0;
      left_q      <= '0;
      blast_q     <= 1'b0;
      out_valid_q <= 1'b0;
      maxlen_q    <= snpd_pkg::MAX_LENGTH_RESET;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      err_q       <= err_d;
      wp_q        <= wp_d;
      produced_q  <= produced_d;
      declared_q  <= declared_d;
      asm_q       <= asm_d;
      litrem_q    <= litrem_d;
      shift_q     <= shift_d;
      left_q      <= left_d;
      blast_q     <= blast_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        maxlen_q <= cfg_i.max_length;
      end
    end
  end

endmodule
